@@ hdl/dbmu_pkg.sv @@
// ----------------------------------------------------------------------------
// dbmu_pkg - shared types and constants
// widths, bound limits, status codes and the saturating store function
// ----------------------------------------------------------------------------
package dbmu_pkg;

  localparam int MAX_VARS = 64;
  localparam int VAR_W    = $clog2(MAX_VARS);
  localparam int CNT_W    = $clog2(MAX_VARS + 1);
  localparam int ADDR_W   = 2 * VAR_W;
  localparam int DEPTH    = MAX_VARS * MAX_VARS;
  localparam int DIST_W   = 32;
  localparam int SUM_W    = DIST_W + 2;
  localparam int BOUND_W  = 31;
  localparam int ACT_W    = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;

  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam dist_t INF_BOUND = 32'sh7FFF_FFFF;
  localparam dist_t MIN_BOUND = 32'sh8000_0000;
  localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

  localparam logic CMD_ASSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_IMPLIED  = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_QUERY    = 2'd3
  } status_t;

  // clamp an exact sum into the stored range
  function automatic dist_t sat(input sum_t v);
    sum_t hi;
    sum_t lo;
    hi = SUM_W'(INF_BOUND);
    lo = SUM_W'(MIN_BOUND);
    if (v > hi) return INF_BOUND;
    else if (v < lo) return MIN_BOUND;
    else return v[DIST_W-1:0];
  endfunction

endpackage

@@ hdl/dbmu_ram.sv @@
// ----------------------------------------------------------------------------
// dbmu_ram - generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dbmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/difference_bound_matrix_update.sv @@
// ----------------------------------------------------------------------------
// difference_bound_matrix_update - incremental difference bound matrix
// keeps shortest bounds x_j - x_i <= d[i][j]; asserts edges with a two-phase
// relaxation (linear scan, then cross relaxation) and answers bound queries
// ----------------------------------------------------------------------------
//
// channel | dir | tdata (low bit up)                          | tuser
// --------+-----+---------------------------------------------+-------------
// in_     | in  | from_var[5:0] to_var[11:6] bound[42:12]     | cmd
//         |     | negate[43] zero[47:44]                      |
// out_    | out | fwd_dist[31:0] back_dist[63:32]             | status[1:0]
// cfg_    | in  | active_vars[6:0] on cfg_wen                 | -
//
// one transaction at a time through a single matrix ram and one adder
// query, conflict or implied edge: read both entries, decide, then load the output register
// applied edge: a linear scan over the active variables, then cross relaxation of
//   the rows and columns the linear scan tightened, skipped when no column tightened
// after reset a clearing pass fills the matrix, in_tready low
// a result waiting on out_tready holds the sequencer before the output stage
//
module difference_bound_matrix_update (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transactions
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dbmu_pkg::IN_TDATA_W-1:0]      in_tdata,   // from_var, to_var, bound, negate
  input  logic                                 in_tuser,   // cmd
  // result transactions
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dbmu_pkg::OUT_TDATA_W-1:0]     out_tdata,  // fwd_dist, back_dist
  output logic [1:0]                           out_tuser,  // status
  // configuration
  input  logic                                 cfg_wen,
  input  logic [dbmu_pkg::ACT_W-1:0]           cfg_wdata   // active_vars
);

  localparam int VW = dbmu_pkg::VAR_W;
  localparam int CW = dbmu_pkg::CNT_W;
  localparam int AW = dbmu_pkg::ADDR_W;
  localparam int SW = dbmu_pkg::SUM_W;

  // sequencer states
  typedef enum logic [21:0] {
    S_CLR  = 22'h000001,
    S_IDLE = 22'h000002,
    S_RA   = 22'h000004,
    S_RB   = 22'h000008,
    S_DEC  = 22'h000010,
    U_R1   = 22'h000020,
    U_R2   = 22'h000040,
    U_W1   = 22'h000080,
    U_R3   = 22'h000100,
    U_R4   = 22'h000200,
    U_W2   = 22'h000400,
    X_LD   = 22'h000800,
    X_LI   = 22'h001000,
    P_J    = 22'h002000,
    P_RD1  = 22'h004000,
    P_RD2  = 22'h008000,
    P_RD3  = 22'h010000,
    P_CMP  = 22'h020000,
    F_RA   = 22'h040000,
    F_RB   = 22'h080000,
    F_CAP  = 22'h100000,
    S_OUT  = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]               clr_r;
  logic [dbmu_pkg::ACT_W-1:0]  active_r;
  logic [VW-1:0]               f_r, t_r, a_r, b_r, i_r, j_r;
  logic                        cmd_r, neg_r;
  dbmu_pkg::dist_t             c_r, w_r, d1_r, d2_r, fwd_r, back_r;
  logic [CW-1:0]               u_r, ni_r, nj_r, x_r, y_r;
  dbmu_pkg::status_t           status_r;

  logic                        out_valid_r;
  logic [dbmu_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [1:0]                  out_user_r;

  // matrix ram port
  logic                        m_we;
  logic [AW-1:0]               m_waddr, m_raddr;
  dbmu_pkg::dist_t             m_wdata, m_rdata;

  // tightened row and column lists from the linear scan
  logic                        row_we, col_we;
  logic [VW-1:0]               row_q, col_q;

  // shared adder and compare
  dbmu_pkg::dist_t             add_a, add_b;
  dbmu_pkg::sum_t              add_sum;
  logic                        tighter;

  logic [CW-1:0]               n_act;
  logic                        in_fire, out_load;
  dbmu_pkg::sum_t              c_x, negc_x, rd_x, fwd_x;

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // active_vars of 0 acts as 1, above the matrix size as the matrix size
  always_comb begin
    if (active_r == '0) begin
      n_act = CW'(1);
    end else if (int'(active_r) > dbmu_pkg::MAX_VARS) begin
      n_act = CW'(dbmu_pkg::MAX_VARS);
    end else begin
      n_act = CW'(active_r);
    end
  end

  // one adder serves the scan and the cross relaxation
  always_comb begin
    add_a = d1_r;
    add_b = (state_r == P_CMP) ? d2_r : w_r;
  end
  assign add_sum = SW'(add_a) + SW'(add_b);
  assign tighter = add_sum < SW'(m_rdata);

  // decision operands, exact
  assign c_x    = SW'(c_r);
  assign negc_x = -c_x;
  assign rd_x   = SW'(m_rdata);
  assign fwd_x  = SW'(fwd_r);

  // ram addressing, one access per cycle under the sequencer
  always_comb begin
    m_we    = 1'b0;
    m_waddr = clr_r;
    m_wdata = dbmu_pkg::INF_BOUND;
    m_raddr = {f_r, t_r};
    row_we  = 1'b0;
    col_we  = 1'b0;
    case (state_r)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = (clr_r[AW-1:VW] == clr_r[VW-1:0]) ? '0 : dbmu_pkg::INF_BOUND;
      end
      S_RA:  m_raddr = {f_r, t_r};
      S_RB:  m_raddr = {t_r, f_r};
      S_DEC: begin
        // the new edge itself
        m_waddr = (neg_r) ? {t_r, f_r} : {f_r, t_r};
        m_wdata = (neg_r) ? dbmu_pkg::sat(negc_x - SW'(1)) : c_r;
        if (cmd_r == dbmu_pkg::CMD_ASSERT) begin
          if (!neg_r) begin
            m_we = !(rd_x < negc_x) && (fwd_x > c_x);
          end else begin
            m_we = !(fwd_x <= c_x) && (rd_x >= negc_x);
          end
        end
      end
      U_R1:  m_raddr = {u_r[VW-1:0], a_r};
      U_R2:  m_raddr = {u_r[VW-1:0], b_r};
      U_W1: begin
        m_waddr = {u_r[VW-1:0], b_r};
        m_wdata = dbmu_pkg::sat(add_sum);
        m_we    = (d1_r != dbmu_pkg::INF_BOUND) && tighter;
        row_we  = m_we;
      end
      U_R3:  m_raddr = {b_r, u_r[VW-1:0]};
      U_R4:  m_raddr = {a_r, u_r[VW-1:0]};
      U_W2: begin
        m_waddr = {a_r, u_r[VW-1:0]};
        m_wdata = dbmu_pkg::sat(add_sum);
        m_we    = (d1_r != dbmu_pkg::INF_BOUND) && tighter;
        col_we  = m_we;
      end
      P_RD1: m_raddr = {i_r, b_r};
      P_RD2: m_raddr = {b_r, j_r};
      P_RD3: m_raddr = {i_r, j_r};
      P_CMP: begin
        m_waddr = {i_r, j_r};
        m_wdata = dbmu_pkg::sat(add_sum);
        m_we    = (i_r != j_r) && tighter;
      end
      F_RA:  m_raddr = {f_r, t_r};
      F_RB:  m_raddr = {t_r, f_r};
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == AW'(dbmu_pkg::DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_fire) state_nxt = S_RA;
      S_RA:   state_nxt = S_RB;
      S_RB:   state_nxt = S_DEC;
      S_DEC:  state_nxt = m_we ? U_R1 : S_OUT;
      U_R1:   state_nxt = U_R2;
      U_R2:   state_nxt = U_W1;
      U_W1:   state_nxt = U_R3;
      U_R3:   state_nxt = U_R4;
      U_R4:   state_nxt = U_W2;
      U_W2:   state_nxt = (u_r + CW'(1) == n_act) ? X_LD : U_R1;
      X_LD:   state_nxt = (x_r == ni_r || nj_r == '0) ? F_RA : X_LI;
      X_LI:   state_nxt = P_J;
      P_J:    state_nxt = P_RD1;
      P_RD1:  state_nxt = P_RD2;
      P_RD2:  state_nxt = P_RD3;
      P_RD3:  state_nxt = P_CMP;
      P_CMP:  state_nxt = (y_r + CW'(1) == nj_r) ? X_LD : P_J;
      F_RA:   state_nxt = F_RB;
      F_RB:   state_nxt = F_CAP;
      F_CAP:  state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      active_r    <= dbmu_pkg::ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_wen) begin
        active_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        f_r   <= in_tdata[VW-1:0];
        t_r   <= in_tdata[6 +: VW];
        c_r   <= dbmu_pkg::DIST_W'($signed(in_tdata[12 +: dbmu_pkg::BOUND_W]));
        neg_r <= in_tdata[43];
        cmd_r <= in_tuser;
      end
      S_RB:  fwd_r <= m_rdata;
      S_DEC: begin
        back_r <= m_rdata;
        u_r    <= '0;
        ni_r   <= '0;
        nj_r   <= '0;
        x_r    <= '0;
        a_r    <= neg_r ? t_r : f_r;
        b_r    <= neg_r ? f_r : t_r;
        w_r    <= neg_r ? dbmu_pkg::sat(negc_x - SW'(1)) : c_r;
        if (cmd_r == dbmu_pkg::CMD_QUERY) begin
          status_r <= dbmu_pkg::ST_QUERY;
        end else if (!neg_r) begin
          if (rd_x < negc_x)     status_r <= dbmu_pkg::ST_CONFLICT;
          else if (fwd_x > c_x)  status_r <= dbmu_pkg::ST_APPLIED;
          else                   status_r <= dbmu_pkg::ST_IMPLIED;
        end else begin
          if (fwd_x <= c_x)        status_r <= dbmu_pkg::ST_CONFLICT;
          else if (rd_x >= negc_x) status_r <= dbmu_pkg::ST_APPLIED;
          else                     status_r <= dbmu_pkg::ST_IMPLIED;
        end
      end
      U_R2:  d1_r <= m_rdata;
      U_W1:  if (row_we) ni_r <= ni_r + CW'(1);
      U_R4:  d1_r <= m_rdata;
      U_W2: begin
        if (col_we) nj_r <= nj_r + CW'(1);
        u_r <= u_r + CW'(1);
      end
      X_LI: begin
        i_r <= row_q;
        y_r <= '0;
      end
      P_RD1: j_r  <= col_q;
      P_RD2: d1_r <= m_rdata;
      P_RD3: d2_r <= m_rdata;
      P_CMP: begin
        if (y_r + CW'(1) == nj_r) x_r <= x_r + CW'(1);
        else y_r <= y_r + CW'(1);
      end
      F_RB:  fwd_r  <= m_rdata;
      F_CAP: back_r <= m_rdata;
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {back_r, fwd_r};
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // bound matrix
  dbmu_ram #(
    .WIDTH (dbmu_pkg::DIST_W),
    .DEPTH (dbmu_pkg::DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // rows whose column b tightened
  dbmu_ram #(
    .WIDTH (VW),
    .DEPTH (dbmu_pkg::MAX_VARS)
  ) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (ni_r[VW-1:0]),
    .wdata (u_r[VW-1:0]),
    .raddr (x_r[VW-1:0]),
    .rdata (row_q)
  );

  // columns whose row a tightened
  dbmu_ram #(
    .WIDTH (VW),
    .DEPTH (dbmu_pkg::MAX_VARS)
  ) u_cols (
    .clk   (clk),
    .we    (col_we),
    .waddr (nj_r[VW-1:0]),
    .wdata (u_r[VW-1:0]),
    .raddr (y_r[VW-1:0]),
    .rdata (col_q)
  );

endmodule

@@ hdl/dbmu_checker.sv @@
// ----------------------------------------------------------------------------
// dbmu_checker - port level checks
// watches the stream ports of the top level over time
// ----------------------------------------------------------------------------
module dbmu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dbmu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [1:0]                        out_tuser
);

  // reset leaves nothing accepted and nothing offered
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ports not quiet after reset");

  // one transaction in flight: not ready right after accepting
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second transaction while busy");

  // a result is never offered right after acceptance
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result offered too early");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind difference_bound_matrix_update dbmu_checker u_dbmu_checker (.*);
